[rtl/core/mwprm_pkg.sv]
`default_nettype none

package mwprm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 13;
    localparam int MAX_WINDOW  = 4096;
    localparam int SUM_W       = 29;
    localparam int DEV_W       = 17;
    localparam int MAG_W       = 16;
    localparam int PROD_W      = 32;
    localparam int SQSUM_W     = 45;
    localparam int ROOT_W      = 16;
    localparam int SQ_IN_W     = 2 * ROOT_W;
    localparam int SQ_REM_W    = ROOT_W + 3;
    localparam int DIV_STEPS   = SQSUM_W;
    localparam int SQ_STEPS    = ROOT_W;
    localparam int ITER_W      = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = LEN_W;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_MODE  = 1'b1;

    localparam logic KIND_CALIBRATE = 1'b0;
    localparam logic KIND_LEVEL     = 1'b1;

    typedef enum logic [3:0] {
        STEP_WAIT,
        STEP_DEV,
        STEP_SQR,
        STEP_ACC,
        STEP_DLOAD,
        STEP_DSTEP,
        STEP_SLOAD,
        STEP_SSTEP,
        STEP_OUT,
        STEP_WRAP
    } step_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_WINDOW_OPEN,
        COND_ITER_MORE,
        COND_CALIBRATE,
        COND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        logic  accept_in;
        logic  do_dev;
        logic  do_sqr;
        logic  do_acc;
        logic  div_load;
        logic  div_step;
        logic  sq_load;
        logic  sq_step;
        logic  do_out;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // microcode rom: one control word per step
    function automatic ctrl_t microcode(input step_t pc);
        ctrl_t cw;
        cw = '{accept_in: 1'b0, do_dev: 1'b0, do_sqr: 1'b0, do_acc: 1'b0,
               div_load: 1'b0, div_step: 1'b0, sq_load: 1'b0, sq_step: 1'b0,
               do_out: 1'b0, cond: COND_ALWAYS, target: STEP_WAIT};
        case (pc)
            STEP_WAIT:
            begin
                cw.accept_in = 1'b1;
                cw.cond      = COND_NO_INPUT;
                cw.target    = STEP_WAIT;
            end
            STEP_DEV:
            begin
                cw.do_dev = 1'b1;
                cw.cond   = COND_NEXT;
            end
            STEP_SQR:
            begin
                cw.do_sqr = 1'b1;
                cw.cond   = COND_NEXT;
            end
            STEP_ACC:
            begin
                cw.do_acc = 1'b1;
                cw.cond   = COND_WINDOW_OPEN;
                cw.target = STEP_WAIT;
            end
            STEP_DLOAD:
            begin
                cw.div_load = 1'b1;
                cw.cond     = COND_NEXT;
            end
            STEP_DSTEP:
            begin
                cw.div_step = 1'b1;
                cw.cond     = COND_ITER_MORE;
                cw.target   = STEP_DSTEP;
            end
            STEP_SLOAD:
            begin
                cw.sq_load = 1'b1;
                cw.cond    = COND_CALIBRATE;
                cw.target  = STEP_OUT;
            end
            STEP_SSTEP:
            begin
                cw.sq_step = 1'b1;
                cw.cond    = COND_ITER_MORE;
                cw.target  = STEP_SSTEP;
            end
            STEP_OUT:
            begin
                cw.do_out = 1'b1;
                cw.cond   = COND_OUT_BLOCKED;
                cw.target = STEP_OUT;
            end
            STEP_WRAP:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_WAIT;
            end
            default:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mic_window_peak_rms_meter_top.sv]
// a non-final sample of a window passes through fetch, deviation, square and accumulate
// the last sample then runs, in measure mode, the bit-serial divide by the window length,
// the two-bits-per-step root and the load/output steps; calibrate mode skips the root
// one word in flight at a time; a result waits in an output register so the next
// window starts while it is held; a blocked output holds the sequencer at its output step
// reset: window length 64, calibrate mode, baseline and all accumulators zero
`default_nettype none

module mic_window_peak_rms_meter_top (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_we,
    input  wire  [mwprm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [mwprm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                    sample_valid,
    output logic                                   sample_stall,
    input  wire  signed [mwprm_pkg::SAMPLE_W-1:0]  sample,
    output logic                                   result_valid,
    input  wire                                    result_stall,
    output logic                                   result_kind,
    output logic [mwprm_pkg::MAG_W-1:0]            peak_level,
    output logic [mwprm_pkg::ROOT_W-1:0]           rms_level,
    output logic signed [mwprm_pkg::SAMPLE_W-1:0]  baseline_out
);

    localparam int SAMPLE_W = mwprm_pkg::SAMPLE_W;
    localparam int LEN_W    = mwprm_pkg::LEN_W;
    localparam int SUM_W    = mwprm_pkg::SUM_W;
    localparam int DEV_W    = mwprm_pkg::DEV_W;
    localparam int MAG_W    = mwprm_pkg::MAG_W;
    localparam int PROD_W   = mwprm_pkg::PROD_W;
    localparam int SQSUM_W  = mwprm_pkg::SQSUM_W;
    localparam int ROOT_W   = mwprm_pkg::ROOT_W;
    localparam int SQ_IN_W  = mwprm_pkg::SQ_IN_W;
    localparam int SQ_REM_W = mwprm_pkg::SQ_REM_W;
    localparam int ITER_W   = mwprm_pkg::ITER_W;

    // sequencer
    mwprm_pkg::step_t pc_reg, pc_next;
    mwprm_pkg::ctrl_t cw;

    // configuration
    logic [LEN_W-1:0] window_length_reg, window_length_next;
    logic             measure_mode_reg, measure_mode_next;
    logic [LEN_W-1:0] eff_len;

    // accumulate datapath
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [LEN_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [MAG_W-1:0]           peak_reg, peak_next;
    logic [SQSUM_W-1:0]         sqsum_reg, sqsum_next;
    logic signed [SAMPLE_W-1:0] baseline_reg, baseline_next;

    // shared divide / square root datapath
    logic [SQSUM_W-1:0]  quo_reg, quo_next;
    logic [LEN_W-1:0]    drem_reg, drem_next;
    logic                neg_reg, neg_next;
    logic [SQ_IN_W-1:0]  sqv_reg, sqv_next;
    logic [SQ_REM_W-1:0] srem_reg, srem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;

    // output word
    logic                       out_valid_reg, out_valid_next;
    logic                       kind_reg, kind_next;
    logic [MAG_W-1:0]           opeak_reg, opeak_next;
    logic [ROOT_W-1:0]          orms_reg, orms_next;
    logic signed [SAMPLE_W-1:0] obase_reg, obase_next;

    logic                       in_take;
    logic                       out_blocked;
    logic                       cond_true;
    logic signed [DEV_W-1:0]    dev;
    logic [LEN_W-1:0]           count_inc;
    logic [SUM_W-1:0]           sum_mag;
    logic [LEN_W:0]             dtrial;
    logic [SQ_REM_W-1:0]        sshift;
    logic [SQ_REM_W-1:0]        strial;
    logic signed [SAMPLE_W-1:0] mean;

    assign cw           = mwprm_pkg::microcode(pc_reg);
    assign sample_stall = !cw.accept_in;
    assign in_take      = sample_valid && cw.accept_in;
    assign out_blocked  = out_valid_reg && result_stall;

    assign result_valid = out_valid_reg;
    assign result_kind  = kind_reg;
    assign peak_level   = opeak_reg;
    assign rms_level    = orms_reg;
    assign baseline_out = obase_reg;

    always_comb
    begin
        if (window_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (window_length_reg > LEN_W'(mwprm_pkg::MAX_WINDOW))
            eff_len = LEN_W'(mwprm_pkg::MAX_WINDOW);
        else
            eff_len = window_length_reg;
    end

    assign count_inc = count_reg + LEN_W'(1);
    assign dev       = DEV_W'(sample_reg) - DEV_W'(baseline_reg);
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dtrial    = {drem_reg, quo_reg[SQSUM_W-1]};
    assign sshift    = {srem_reg[SQ_REM_W-3:0], sqv_reg[SQ_IN_W-1:SQ_IN_W-2]};
    assign strial    = {1'b0, root_reg, 2'b01};
    assign mean      = neg_reg ? -SAMPLE_W'(quo_reg) : SAMPLE_W'(quo_reg);

    always_comb
    begin
        case (cw.cond)
            mwprm_pkg::COND_NEXT:        cond_true = 1'b0;
            mwprm_pkg::COND_ALWAYS:      cond_true = 1'b1;
            mwprm_pkg::COND_NO_INPUT:    cond_true = !in_take;
            mwprm_pkg::COND_WINDOW_OPEN: cond_true = count_inc < eff_len;
            mwprm_pkg::COND_ITER_MORE:   cond_true = iter_reg != '0;
            mwprm_pkg::COND_CALIBRATE:   cond_true = !measure_mode_reg;
            mwprm_pkg::COND_OUT_BLOCKED: cond_true = out_blocked;
            default:                     cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next            = cond_true ? cw.target : mwprm_pkg::step_t'(pc_reg + 4'd1);
        window_length_next = window_length_reg;
        measure_mode_next  = measure_mode_reg;
        sample_next        = sample_reg;
        mag_next           = mag_reg;
        prod_next          = prod_reg;
        count_next         = count_reg;
        sum_next           = sum_reg;
        peak_next          = peak_reg;
        sqsum_next         = sqsum_reg;
        baseline_next      = baseline_reg;
        quo_next           = quo_reg;
        drem_next          = drem_reg;
        neg_next           = neg_reg;
        sqv_next           = sqv_reg;
        srem_next          = srem_reg;
        root_next          = root_reg;
        iter_next          = iter_reg;
        out_valid_next     = out_valid_reg && result_stall;
        kind_next          = kind_reg;
        opeak_next         = opeak_reg;
        orms_next          = orms_reg;
        obase_next         = obase_reg;

        if (in_take)
            sample_next = sample;

        if (cw.do_dev)
            mag_next = MAG_W'(dev[DEV_W-1] ? -dev : dev);

        if (cw.do_sqr)
            prod_next = PROD_W'(mag_reg) * PROD_W'(mag_reg);

        if (cw.do_acc)
        begin
            count_next = count_inc;
            if (measure_mode_reg)
            begin
                sqsum_next = sqsum_reg + SQSUM_W'(prod_reg);
                if (mag_reg > peak_reg)
                    peak_next = mag_reg;
            end
            else
            begin
                sum_next = sum_reg + SUM_W'(sample_reg);
            end
        end

        if (cw.div_load)
        begin
            quo_next  = measure_mode_reg ? sqsum_reg : SQSUM_W'(sum_mag);
            neg_next  = !measure_mode_reg && sum_reg[SUM_W-1];
            drem_next = '0;
            iter_next = ITER_W'(mwprm_pkg::DIV_STEPS - 1);
        end

        // restoring divide, one quotient bit per step
        if (cw.div_step)
        begin
            iter_next = iter_reg - ITER_W'(1);
            if (dtrial >= {1'b0, eff_len})
            begin
                drem_next = LEN_W'(dtrial - {1'b0, eff_len});
                quo_next  = {quo_reg[SQSUM_W-2:0], 1'b1};
            end
            else
            begin
                drem_next = LEN_W'(dtrial);
                quo_next  = {quo_reg[SQSUM_W-2:0], 1'b0};
            end
        end

        // mean square is below 2^32, so the low 32 bits feed the root
        if (cw.sq_load)
        begin
            sqv_next  = SQ_IN_W'(quo_reg);
            srem_next = '0;
            root_next = '0;
            iter_next = ITER_W'(mwprm_pkg::SQ_STEPS - 1);
        end

        // digit-by-digit root, two radicand bits per step
        if (cw.sq_step)
        begin
            iter_next = iter_reg - ITER_W'(1);
            sqv_next  = {sqv_reg[SQ_IN_W-3:0], 2'b00};
            if (sshift >= strial)
            begin
                srem_next = sshift - strial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_next = sshift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end

        if (cw.do_out && !out_blocked)
        begin
            out_valid_next = 1'b1;
            if (measure_mode_reg)
            begin
                kind_next  = mwprm_pkg::KIND_LEVEL;
                opeak_next = peak_reg;
                orms_next  = root_reg;
                obase_next = baseline_reg;
            end
            else
            begin
                kind_next     = mwprm_pkg::KIND_CALIBRATE;
                opeak_next    = '0;
                orms_next     = '0;
                obase_next    = mean;
                baseline_next = mean;
            end
            count_next = '0;
            sum_next   = '0;
            peak_next  = '0;
            sqsum_next = '0;
        end

        // a register write restarts the window and keeps the baseline
        if (cfg_we)
        begin
            case (cfg_index)
                mwprm_pkg::REG_WINDOW_LENGTH: window_length_next = cfg_data;
                mwprm_pkg::REG_MEASURE_MODE:  measure_mode_next  = cfg_data[0];
                default:                      window_length_next = window_length_reg;
            endcase
            count_next = '0;
            sum_next   = '0;
            peak_next  = '0;
            sqsum_next = '0;
            pc_next    = mwprm_pkg::STEP_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg            <= mwprm_pkg::STEP_WAIT;
            window_length_reg <= LEN_W'(64);
            measure_mode_reg  <= 1'b0;
            count_reg         <= '0;
            sum_reg           <= '0;
            peak_reg          <= '0;
            sqsum_reg         <= '0;
            baseline_reg      <= '0;
            iter_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            pc_reg            <= pc_next;
            window_length_reg <= window_length_next;
            measure_mode_reg  <= measure_mode_next;
            count_reg         <= count_next;
            sum_reg           <= sum_next;
            peak_reg          <= peak_next;
            sqsum_reg         <= sqsum_next;
            baseline_reg      <= baseline_next;
            iter_reg          <= iter_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        mag_reg    <= mag_next;
        prod_reg   <= prod_next;
        quo_reg    <= quo_next;
        drem_reg   <= drem_next;
        neg_reg    <= neg_next;
        sqv_reg    <= sqv_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        kind_reg   <= kind_next;
        opeak_reg  <= opeak_next;
        orms_reg   <= orms_next;
        obase_reg  <= obase_next;
    end

endmodule

`default_nettype wire
